// ===== hw/rtl/cdh_pkg.sv =====
package cdh_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int VALUE_W     = 11;
   localparam int THR_W       = 11;
   localparam int SENSOR_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int TUSER_W     = 3;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam logic KIND_CAL  = 1'b0;
   localparam logic KIND_MEAS = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CONTACT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEADY  = 2'd2;

   localparam logic [THR_W-1:0] CONTACT_RESET = 11'd5;
   localparam logic [THR_W-1:0] RELEASE_RESET = 11'd2;
   localparam logic [THR_W-1:0] STEADY_RESET  = 11'd2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_VALUE = 5'b00100,
      S_SCAN  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      OP_OFFSET,
      OP_DIFF
   } sub_op_type;

   typedef struct packed {
      logic                add;
      logic                wr_offset;
      logic                kind;
      logic [SENSOR_W-1:0] sensor;
   } acc_ctl_type;

   typedef struct packed {
      logic push;
      logic rotate;
   } hist_ctl_type;

endpackage

// ===== hw/rtl/cdh_sub.sv =====
module cdh_sub #(
   parameter int SUB_W = 12
) (
   input  cdh_pkg::sub_op_type                  op,
   input  logic        [cdh_pkg::SAMPLE_W-1:0]  quo,
   input  logic        [cdh_pkg::SAMPLE_W-1:0]  offset,
   input  logic signed [cdh_pkg::VALUE_W-1:0]   tap0,
   input  logic signed [cdh_pkg::VALUE_W-1:0]   tap1,
   output logic signed [SUB_W-1:0]              diff
);

   logic signed [SUB_W-1:0] opa;
   logic signed [SUB_W-1:0] opb;

   always_comb begin
      case (op)
         cdh_pkg::OP_OFFSET: begin
            opa = {{(SUB_W-cdh_pkg::SAMPLE_W){1'b0}}, quo};
            opb = {{(SUB_W-cdh_pkg::SAMPLE_W){1'b0}}, offset};
         end
         cdh_pkg::OP_DIFF: begin
            opa = {{(SUB_W-cdh_pkg::VALUE_W){tap0[cdh_pkg::VALUE_W-1]}}, tap0};
            opb = {{(SUB_W-cdh_pkg::VALUE_W){tap1[cdh_pkg::VALUE_W-1]}}, tap1};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      diff = opa - opb;
   end

endmodule

// ===== hw/rtl/cdh_accum.sv =====
module cdh_accum #(
   parameter int SENSORS      = 4,
   parameter int CAL_SAMPLES  = 200,
   parameter int READ_SAMPLES = 20,
   parameter int DIV_W        = 18
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cdh_pkg::acc_ctl_type             ctl,
   input  logic [cdh_pkg::SAMPLE_W-1:0]     sample,
   input  logic [cdh_pkg::SAMPLE_W-1:0]     offset_wdata,
   output logic                             done,
   output logic [DIV_W-1:0]                 sum,
   output logic [cdh_pkg::SAMPLE_W-1:0]     offset
);

   localparam int SAMPLE_MAX = (1 << cdh_pkg::SAMPLE_W) - 1;
   localparam int CAL_SUM_W  = $clog2(CAL_SAMPLES * SAMPLE_MAX + 1);
   localparam int CAL_CNT_W  = $clog2(CAL_SAMPLES + 1);
   localparam int RD_SUM_W   = $clog2(READ_SAMPLES * SAMPLE_MAX + 1);
   localparam int RD_CNT_W   = $clog2(READ_SAMPLES + 1);

   logic [CAL_SUM_W-1:0]         cal_sum_ff [SENSORS];
   logic [CAL_SUM_W-1:0]         cal_sum_in [SENSORS];
   logic [CAL_CNT_W-1:0]         cal_cnt_ff [SENSORS];
   logic [CAL_CNT_W-1:0]         cal_cnt_in [SENSORS];
   logic [RD_SUM_W-1:0]          rd_sum_ff  [SENSORS];
   logic [RD_SUM_W-1:0]          rd_sum_in  [SENSORS];
   logic [RD_CNT_W-1:0]          rd_cnt_ff  [SENSORS];
   logic [RD_CNT_W-1:0]          rd_cnt_in  [SENSORS];
   logic [cdh_pkg::SAMPLE_W-1:0] offset_ff  [SENSORS];
   logic [cdh_pkg::SAMPLE_W-1:0] offset_in  [SENSORS];

   logic [CAL_SUM_W-1:0]         cal_sum_sel;
   logic [CAL_CNT_W-1:0]         cal_cnt_sel;
   logic [RD_SUM_W-1:0]          rd_sum_sel;
   logic [RD_CNT_W-1:0]          rd_cnt_sel;
   logic [CAL_SUM_W-1:0]         cal_sum_nx;
   logic [CAL_CNT_W-1:0]         cal_cnt_nx;
   logic [RD_SUM_W-1:0]          rd_sum_nx;
   logic [RD_CNT_W-1:0]          rd_cnt_nx;
   logic                         cal_done;
   logic                         rd_done;

   always_comb begin
      cal_sum_sel = '0;
      cal_cnt_sel = '0;
      rd_sum_sel  = '0;
      rd_cnt_sel  = '0;
      offset      = '0;
      for (int i = 0; i < SENSORS; i++) begin
         if (32'(ctl.sensor) == i) begin
            cal_sum_sel = cal_sum_ff[i];
            cal_cnt_sel = cal_cnt_ff[i];
            rd_sum_sel  = rd_sum_ff[i];
            rd_cnt_sel  = rd_cnt_ff[i];
            offset      = offset_ff[i];
         end
      end
      cal_sum_nx = cal_sum_sel + CAL_SUM_W'(sample);
      cal_cnt_nx = cal_cnt_sel + CAL_CNT_W'(1);
      rd_sum_nx  = rd_sum_sel + RD_SUM_W'(sample);
      rd_cnt_nx  = rd_cnt_sel + RD_CNT_W'(1);
      cal_done   = (cal_cnt_nx == CAL_CNT_W'(CAL_SAMPLES));
      rd_done    = (rd_cnt_nx == RD_CNT_W'(READ_SAMPLES));
      if (ctl.kind == cdh_pkg::KIND_CAL) begin
         done = ctl.add && cal_done;
         sum  = DIV_W'(cal_sum_nx);
      end else begin
         done = ctl.add && rd_done;
         sum  = DIV_W'(rd_sum_nx);
      end
   end

   always_comb begin
      for (int i = 0; i < SENSORS; i++) begin
         cal_sum_in[i] = cal_sum_ff[i];
         cal_cnt_in[i] = cal_cnt_ff[i];
         rd_sum_in[i]  = rd_sum_ff[i];
         rd_cnt_in[i]  = rd_cnt_ff[i];
         offset_in[i]  = offset_ff[i];
         if (32'(ctl.sensor) == i) begin
            if (ctl.add && ctl.kind == cdh_pkg::KIND_CAL) begin
               cal_sum_in[i] = cal_done ? '0 : cal_sum_nx;
               cal_cnt_in[i] = cal_done ? '0 : cal_cnt_nx;
            end
            if (ctl.add && ctl.kind == cdh_pkg::KIND_MEAS) begin
               rd_sum_in[i] = rd_done ? '0 : rd_sum_nx;
               rd_cnt_in[i] = rd_done ? '0 : rd_cnt_nx;
            end
            if (ctl.wr_offset) begin
               offset_in[i] = offset_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SENSORS; i++) begin
         if (reset) begin
            cal_sum_ff[i] <= '0;
            cal_cnt_ff[i] <= '0;
            rd_sum_ff[i]  <= '0;
            rd_cnt_ff[i]  <= '0;
            offset_ff[i]  <= '0;
         end else begin
            cal_sum_ff[i] <= cal_sum_in[i];
            cal_cnt_ff[i] <= cal_cnt_in[i];
            rd_sum_ff[i]  <= rd_sum_in[i];
            rd_cnt_ff[i]  <= rd_cnt_in[i];
            offset_ff[i]  <= offset_in[i];
         end
      end
   end

endmodule

// ===== hw/rtl/cdh_hist.sv =====
module cdh_hist #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdh_pkg::hist_ctl_type              ctl,
   input  logic signed [cdh_pkg::VALUE_W-1:0] push_data,
   output logic signed [cdh_pkg::VALUE_W-1:0] tap0,
   output logic signed [cdh_pkg::VALUE_W-1:0] tap1
);

   logic signed [cdh_pkg::VALUE_W-1:0] hist_ff [HISTORY_DEPTH];
   logic signed [cdh_pkg::VALUE_W-1:0] hist_in [HISTORY_DEPTH];

   // A rotation moves every entry one place toward the head, so a full turn
   // presents each adjacent pair at the two head taps and restores the order.
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (ctl.push) begin
         hist_in[0] = push_data;
         for (int i = 1; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = hist_ff[i-1];
         end
      end else if (ctl.rotate) begin
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            hist_in[i] = hist_ff[i+1];
         end
         hist_in[HISTORY_DEPTH-1] = hist_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (reset) begin
            hist_ff[i] <= '0;
         end else begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   assign tap0 = hist_ff[0];
   assign tap1 = hist_ff[1];

endmodule

// ===== hw/rtl/contact_detect_hysteresis.sv =====
// Averages raw ADC samples per sensor, keeps a calibration offset for each
// sensor and tracks a contact flag with hysteresis on sensor 0. A sample that
// does not complete an average is absorbed while the block stays idle. A sample
// that completes one keeps the block busy until it is ready again: the DIV
// state divides the sum by multiplying it with a fixed-point reciprocal of
// the sample count, the VALUE state removes the offset in the shared
// subtractor, then in the SCAN state the subtractor forms one adjacent history
// difference per cycle while the history rotates through a full turn, and the
// OUT state loads the result register. A result still waiting on rsp_tready
// when the next average completes holds the block in its output step, and no
// beat is accepted until that result is taken.
module contact_detect_hysteresis #(
   parameter int SENSORS       = 4,
   parameter int HISTORY_DEPTH = 8,
   parameter int CAL_SAMPLES   = 200,
   parameter int READ_SAMPLES  = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cdh_pkg::REQ_TDATA_W-1:0]    req_tdata,  // sample
   input  logic [cdh_pkg::TUSER_W-1:0]        req_tuser,  // kind, sensor_index
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cdh_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // value, contact, max_change, steady
   output logic [cdh_pkg::TUSER_W-1:0]        rsp_tuser,  // result_kind, result_sensor
   input  logic                               csr_we,
   input  logic [cdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cdh_pkg::THR_W-1:0]          csr_wdata
);

   localparam int SAMPLE_MAX = (1 << cdh_pkg::SAMPLE_W) - 1;
   localparam int CAL_SUM_W  = $clog2(CAL_SAMPLES * SAMPLE_MAX + 1);
   localparam int RD_SUM_W   = $clog2(READ_SAMPLES * SAMPLE_MAX + 1);
   localparam int DIV_W      = (CAL_SUM_W > RD_SUM_W) ? CAL_SUM_W : RD_SUM_W;
   localparam int CAL_LOG    = $clog2(CAL_SAMPLES);
   localparam int RD_LOG     = $clog2(READ_SAMPLES);
   localparam int RECIP_SH   = DIV_W + ((CAL_LOG > RD_LOG) ? CAL_LOG : RD_LOG);
   localparam int RECIP_W    = RECIP_SH + 1;
   localparam int PROD_W     = DIV_W + RECIP_W;
   localparam longint RECIP_ONE = longint'(1) << RECIP_SH;
   localparam longint RECIP_CAL = (RECIP_ONE + CAL_SAMPLES - 1) / CAL_SAMPLES;
   localparam longint RECIP_RD  = (RECIP_ONE + READ_SAMPLES - 1) / READ_SAMPLES;
   localparam int SUB_W      = cdh_pkg::VALUE_W + 1;
   localparam int STEP_W     = $clog2(HISTORY_DEPTH);

   cdh_pkg::state_type                  state_ff, state_in;
   logic                                kind_ff, kind_in;
   logic [cdh_pkg::SENSOR_W-1:0]        sensor_ff, sensor_in;
   logic [DIV_W-1:0]                    sum_ff, sum_in;
   logic [cdh_pkg::SAMPLE_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic [cdh_pkg::VALUE_W-1:0]         val_ff, val_in;
   logic [cdh_pkg::THR_W-1:0]           big_ff, big_in;
   logic                                calm_ff, calm_in;
   logic                                contact_ff, contact_in;
   logic [cdh_pkg::THR_W-1:0]           contact_thr_ff;
   logic [cdh_pkg::THR_W-1:0]           release_thr_ff;
   logic [cdh_pkg::THR_W-1:0]           steady_thr_ff;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [cdh_pkg::RSP_TDATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic [cdh_pkg::TUSER_W-1:0]         rsp_tuser_ff, rsp_tuser_in;

   logic                                req_kind;
   logic [cdh_pkg::SENSOR_W-1:0]        req_sensor;
   logic [cdh_pkg::SAMPLE_W-1:0]        req_sample;
   logic                                req_fire;
   logic                                sensor_ok;
   logic                                hist_upd;
   logic                                load_out;

   cdh_pkg::acc_ctl_type                acc_ctl;
   cdh_pkg::hist_ctl_type               hist_ctl;
   cdh_pkg::sub_op_type                 sub_op;
   logic                                acc_done;
   logic [DIV_W-1:0]                    acc_sum;
   logic [cdh_pkg::SAMPLE_W-1:0]        offset;
   logic [RECIP_W-1:0]                  recip;
   logic [PROD_W-1:0]                   product;
   logic signed [SUB_W-1:0]             diff;
   logic signed [SUB_W-1:0]             diff_abs;
   logic [cdh_pkg::THR_W-1:0]           change;
   logic signed [cdh_pkg::VALUE_W-1:0]  tap0;
   logic signed [cdh_pkg::VALUE_W-1:0]  tap1;

   assign req_kind   = req_tuser[0];
   assign req_sensor = req_tuser[cdh_pkg::SENSOR_W:1];
   assign req_sample = req_tdata[cdh_pkg::SAMPLE_W-1:0];
   assign req_tready = (state_ff == cdh_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign sensor_ok  = (32'(req_sensor) < SENSORS);
   assign hist_upd   = (kind_ff == cdh_pkg::KIND_MEAS) && (sensor_ff == '0);
   assign load_out   = (state_ff == cdh_pkg::S_OUT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      acc_ctl.add       = req_fire && sensor_ok;
      acc_ctl.wr_offset = (state_ff == cdh_pkg::S_VALUE) && (kind_ff == cdh_pkg::KIND_CAL);
      acc_ctl.kind      = req_tready ? req_kind : kind_ff;
      acc_ctl.sensor    = req_tready ? req_sensor : sensor_ff;
      hist_ctl.push     = (state_ff == cdh_pkg::S_VALUE) && hist_upd;
      hist_ctl.rotate   = (state_ff == cdh_pkg::S_SCAN);
      case (state_ff)
         cdh_pkg::S_VALUE: sub_op = cdh_pkg::OP_OFFSET;
         default:          sub_op = cdh_pkg::OP_DIFF;
      endcase
      // The reciprocal is rounded up and has enough fraction bits that the
      // product gives the exact floor of the average for every possible sum.
      recip    = (kind_ff == cdh_pkg::KIND_CAL) ? RECIP_W'(RECIP_CAL) : RECIP_W'(RECIP_RD);
      product  = PROD_W'(sum_ff) * PROD_W'(recip);
      diff_abs = diff[SUB_W-1] ? -diff : diff;
      change   = diff_abs[cdh_pkg::THR_W-1:0];
   end

   cdh_accum #(
      .SENSORS      (SENSORS),
      .CAL_SAMPLES  (CAL_SAMPLES),
      .READ_SAMPLES (READ_SAMPLES),
      .DIV_W        (DIV_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .ctl          (acc_ctl),
      .sample       (req_sample),
      .offset_wdata (quo_ff),
      .done         (acc_done),
      .sum          (acc_sum),
      .offset       (offset)
   );

   cdh_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hist_ctl),
      .push_data (diff[cdh_pkg::VALUE_W-1:0]),
      .tap0      (tap0),
      .tap1      (tap1)
   );

   cdh_sub #(
      .SUB_W (SUB_W)
   ) u_sub (
      .op     (sub_op),
      .quo    (quo_ff),
      .offset (offset),
      .tap0   (tap0),
      .tap1   (tap1),
      .diff   (diff)
   );

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      sensor_in  = sensor_ff;
      sum_in     = sum_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      val_in     = val_ff;
      big_in     = big_ff;
      calm_in    = calm_ff;
      contact_in = contact_ff;
      case (state_ff)
         cdh_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_in   = req_kind;
               sensor_in = req_sensor;
               sum_in    = acc_sum;
               if (acc_done) begin
                  state_in = cdh_pkg::S_DIV;
               end
            end
         end
         cdh_pkg::S_DIV: begin
            quo_in   = product[RECIP_SH +: cdh_pkg::SAMPLE_W];
            state_in = cdh_pkg::S_VALUE;
         end
         cdh_pkg::S_VALUE: begin
            if (kind_ff == cdh_pkg::KIND_CAL) begin
               val_in = {1'b0, quo_ff};
            end else begin
               val_in = diff[cdh_pkg::VALUE_W-1:0];
            end
            step_in  = '0;
            big_in   = '0;
            calm_in  = 1'b1;
            state_in = cdh_pkg::S_SCAN;
         end
         cdh_pkg::S_SCAN: begin
            if (step_ff == STEP_W'(HISTORY_DEPTH - 1)) begin
               if (hist_upd) begin
                  if (!contact_ff) begin
                     contact_in = (big_ff >= contact_thr_ff);
                  end else begin
                     contact_in = !(big_ff < release_thr_ff);
                  end
               end
               state_in = cdh_pkg::S_OUT;
            end else begin
               if (change > big_ff) begin
                  big_in = change;
               end
               if (change >= steady_thr_ff) begin
                  calm_in = 1'b0;
               end
               step_in = step_ff + STEP_W'(1);
            end
         end
         cdh_pkg::S_OUT: begin
            if (load_out) begin
               state_in = cdh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cdh_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {calm_ff, big_ff, contact_ff, val_ff};
         rsp_tuser_in  = {sensor_ff, kind_ff};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cdh_pkg::S_IDLE;
         contact_ff     <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         contact_thr_ff <= cdh_pkg::CONTACT_RESET;
         release_thr_ff <= cdh_pkg::RELEASE_RESET;
         steady_thr_ff  <= cdh_pkg::STEADY_RESET;
      end else begin
         state_ff      <= state_in;
         contact_ff    <= contact_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            case (csr_index)
               cdh_pkg::REG_CONTACT: contact_thr_ff <= csr_wdata;
               cdh_pkg::REG_RELEASE: release_thr_ff <= csr_wdata;
               cdh_pkg::REG_STEADY:  steady_thr_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      sensor_ff    <= sensor_in;
      sum_ff       <= sum_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      val_ff       <= val_in;
      big_ff       <= big_in;
      calm_ff      <= calm_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== hw/rtl/cdh_checker.sv =====
module cdh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cdh_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [cdh_pkg::TUSER_W-1:0]     rsp_tuser
);

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // An offset is an average of raw samples and is never negative.
   a_offset_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == cdh_pkg::KIND_CAL |->
         rsp_tdata[cdh_pkg::VALUE_W-1] == 1'b0)
      else $error("negative offset reported");

   // A difference of two readings never exceeds twice the sample range.
   a_change_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:12] != 11'h7ff)
      else $error("max change out of range");

endmodule

bind contact_detect_hysteresis cdh_checker u_cdh_checker (.*);

// ===== bench/tb_contact_detect_hysteresis.sv =====
module tb_contact_detect_hysteresis;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SENSOR_COUNT    = 4;
   localparam int HIST_DEPTH      = 8;
   localparam int CAL_LEN         = 200;
   localparam int READ_LEN        = 20;
   localparam int DRAIN_CYCLES    = 30;
   localparam int STALL_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 270;
   localparam int NO_CAL          = -1;

   localparam logic [cdh_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic                         kind;
      logic [cdh_pkg::SENSOR_W-1:0] sensor;
      logic [cdh_pkg::VALUE_W-1:0]  value;
      logic                         contact;
      logic [cdh_pkg::THR_W-1:0]    max_change;
      logic                         steady;
   } sensor_result_type;

   class contact_scoreboard;
      logic [cdh_pkg::THR_W-1:0] contact_thr;
      logic [cdh_pkg::THR_W-1:0] release_thr;
      logic [cdh_pkg::THR_W-1:0] steady_thr;
      logic [9:0]                offset   [SENSOR_COUNT];
      logic [17:0]               cal_sum  [SENSOR_COUNT];
      logic [7:0]                cal_cnt  [SENSOR_COUNT];
      logic [14:0]               meas_sum [SENSOR_COUNT];
      logic [4:0]                meas_cnt [SENSOR_COUNT];
      int                        history  [HIST_DEPTH];
      logic                      contact;
      sensor_result_type         due [$];
      int                        mismatches;

      function void power_on();
         contact_thr = cdh_pkg::CONTACT_RESET;
         release_thr = cdh_pkg::RELEASE_RESET;
         steady_thr  = cdh_pkg::STEADY_RESET;
         foreach (offset[i]) begin
            offset[i]   = '0;
            cal_sum[i]  = '0;
            cal_cnt[i]  = '0;
            meas_sum[i] = '0;
            meas_cnt[i] = '0;
         end
         foreach (history[i]) history[i] = 0;
         contact    = 1'b0;
         mismatches = 0;
         due.delete();
      endfunction

      function void write_reg(logic [cdh_pkg::CSR_IDX_W-1:0] idx,
                              logic [cdh_pkg::THR_W-1:0] data);
         case (idx)
            cdh_pkg::REG_CONTACT: contact_thr = data;
            cdh_pkg::REG_RELEASE: release_thr = data;
            cdh_pkg::REG_STEADY:  steady_thr  = data;
            default: ;
         endcase
      endfunction

      function int unsigned largest_step(output logic calm);
         int unsigned biggest;
         int unsigned step;
         biggest = 0;
         calm    = 1'b1;
         for (int i = 0; i < HIST_DEPTH - 1; i++) begin
            step = (history[i] > history[i+1]) ? history[i] - history[i+1]
                                               : history[i+1] - history[i];
            if (step > biggest) biggest = step;
            if (step >= steady_thr) calm = 1'b0;
         end
         return biggest;
      endfunction

      function void note_sample(logic kind, logic [cdh_pkg::SENSOR_W-1:0] sensor,
                                logic [9:0] sample);
         sensor_result_type r;
         int                avg;
         int unsigned       biggest;
         logic              calm;
         if (kind == cdh_pkg::KIND_CAL) begin
            cal_sum[sensor] += sample;
            cal_cnt[sensor] += 1;
            if (cal_cnt[sensor] < CAL_LEN) return;
            offset[sensor]  = 10'(cal_sum[sensor] / CAL_LEN);
            cal_sum[sensor] = '0;
            cal_cnt[sensor] = '0;
            r.value = cdh_pkg::VALUE_W'(offset[sensor]);
            biggest = largest_step(calm);
         end else begin
            meas_sum[sensor] += sample;
            meas_cnt[sensor] += 1;
            if (meas_cnt[sensor] < READ_LEN) return;
            avg = int'(meas_sum[sensor] / READ_LEN) - int'(offset[sensor]);
            meas_sum[sensor] = '0;
            meas_cnt[sensor] = '0;
            if (sensor == 0) begin
               for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
               history[0] = avg;
               biggest = largest_step(calm);
               if (!contact) begin
                  if (biggest >= contact_thr) contact = 1'b1;
               end else if (biggest < release_thr) begin
                  contact = 1'b0;
               end
            end else begin
               biggest = largest_step(calm);
            end
            r.value = cdh_pkg::VALUE_W'(avg);
         end
         r.kind       = kind;
         r.sensor     = sensor;
         r.contact    = contact;
         r.max_change = cdh_pkg::THR_W'(biggest);
         r.steady     = calm;
         due.push_back(r);
      endfunction

      function void check_result(sensor_result_type got);
         sensor_result_type want;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat kind %0d sensor %0d value %0d",
                        $time, got.kind, got.sensor, $signed(got.value));
            return;
         end
         want = due.pop_front();
         if (got.kind !== want.kind || got.sensor !== want.sensor ||
             got.value !== want.value || got.contact !== want.contact ||
             got.max_change !== want.max_change || got.steady !== want.steady) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: expected kind %0d sensor %0d value %0d contact %0d max %0d steady %0d",
                        $time, want.kind, want.sensor, $signed(want.value), want.contact,
                        want.max_change, want.steady);
               $display("%0t: actual   kind %0d sensor %0d value %0d contact %0d max %0d steady %0d",
                        $time, got.kind, got.sensor, $signed(got.value), got.contact,
                        got.max_change, got.steady);
            end
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cdh_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [cdh_pkg::TUSER_W-1:0]     req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [cdh_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [cdh_pkg::TUSER_W-1:0]     rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [cdh_pkg::CSR_IDX_W-1:0]   csr_index  = '0;
   logic [cdh_pkg::THR_W-1:0]       csr_wdata  = '0;

   contact_scoreboard sb;
   int                level [SENSOR_COUNT] = '{512, 512, 512, 512};
   logic              no_gaps      = 1'b0;
   logic              hold_request = 1'b0;
   int                hold_left    = 0;
   int                quiet_cycles = 0;

   contact_detect_hysteresis #(
      .SENSORS      (SENSOR_COUNT),
      .HISTORY_DEPTH(HIST_DEPTH),
      .CAL_SAMPLES  (CAL_LEN),
      .READ_SAMPLES (READ_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_OFF_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 7);
      end
   end

   always @(posedge clock) begin
      sensor_result_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind       = rsp_tuser[0];
         seen.sensor     = rsp_tuser[2:1];
         seen.value      = rsp_tdata[10:0];
         seen.contact    = rsp_tdata[11];
         seen.max_change = rsp_tdata[22:12];
         seen.steady     = rsp_tdata[23];
         sb.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic offer_sample(input logic kind, input logic [cdh_pkg::SENSOR_W-1:0] sensor,
                               input logic [9:0] sample);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(cdh_pkg::REQ_TDATA_W-cdh_pkg::SAMPLE_W){1'b0}}, sample};
      req_tuser  <= {sensor, kind};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(kind, sensor, sample);
   endtask

   task automatic write_csr(input logic [cdh_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cdh_pkg::THR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic write_thresholds(input logic [cdh_pkg::THR_W-1:0] c_thr,
                                   input logic [cdh_pkg::THR_W-1:0] r_thr,
                                   input logic [cdh_pkg::THR_W-1:0] s_thr);
      write_csr(cdh_pkg::REG_CONTACT, c_thr);
      write_csr(cdh_pkg::REG_RELEASE, r_thr);
      write_csr(cdh_pkg::REG_STEADY, s_thr);
      write_csr(REG_SPARE, cdh_pkg::THR_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Stops offering beats, waits for every pending result and lets the block go idle.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [9:0] cal_value(input int sensor);
      case (sensor)
         0:       return 10'($urandom_range(300, 700));
         1:       return 10'(1023 - $urandom_range(0, 3));
         2:       return 10'($urandom_range(0, 4));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // Readings drift slowly around a level per sensor, with rare jumps to the
   // rails and occasional wild samples, so the change detector sees small and
   // large steps alike.
   function automatic logic [9:0] meas_value(input int sensor);
      int v;
      if ($urandom_range(0, 19) == 0) begin
         if ($urandom_range(0, 9) == 0)
            level[sensor] = $urandom_range(0, 1) ? 1023 : 0;
         else
            level[sensor] = level[sensor] + int'($urandom_range(0, 12)) - 6;
         if (level[sensor] < 0) level[sensor] = 0;
         if (level[sensor] > 1023) level[sensor] = 1023;
      end
      if ($urandom_range(0, 99) < 5) return 10'($urandom_range(0, 1023));
      v = level[sensor] + int'($urandom_range(0, 3));
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   task automatic run_phase(input int cal_sensor);
      int cal_left;
      int sensor;
      cal_left = (cal_sensor >= 0) ? CAL_LEN : 0;
      for (int n = ITEMS_PER_PHASE; n > 0; n--) begin
         if (cal_left > 0 && (cal_left >= n || $urandom_range(0, 99) < 74)) begin
            cal_left--;
            offer_sample(cdh_pkg::KIND_CAL, cdh_pkg::SENSOR_W'(cal_sensor),
                         cal_value(cal_sensor));
         end else begin
            sensor = ($urandom_range(0, 99) < 60) ? 0 : int'($urandom_range(0, 3));
            offer_sample(cdh_pkg::KIND_MEAS, cdh_pkg::SENSOR_W'(sensor), meas_value(sensor));
         end
      end
   endtask

   initial begin
      logic [cdh_pkg::THR_W-1:0] c_thr;
      sb = new;
      sb.power_on();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int s = 0; s < SENSOR_COUNT; s++) begin
         offer_sample(cdh_pkg::KIND_CAL, cdh_pkg::SENSOR_W'(s), 10'h000);
         offer_sample(cdh_pkg::KIND_CAL, cdh_pkg::SENSOR_W'(s), 10'h3FF);
         offer_sample(cdh_pkg::KIND_MEAS, cdh_pkg::SENSOR_W'(s), 10'h000);
         offer_sample(cdh_pkg::KIND_MEAS, cdh_pkg::SENSOR_W'(s), 10'h3FF);
      end
      offer_sample(cdh_pkg::KIND_MEAS, '0, 10'h2AA);
      offer_sample(cdh_pkg::KIND_MEAS, '0, 10'h155);

      // The receiver stalls while readings keep arriving, so a second completed
      // average has to wait and the input side backs up.
      hold_request = 1'b1;
      run_phase(NO_CAL);
      settle();

      write_thresholds(11'd0, 11'd0, 11'd0);
      run_phase(0);
      settle();

      write_thresholds(11'd2047, 11'd2047, 11'd2047);
      run_phase(1);
      settle();

      write_thresholds(11'd8, 11'd3, 11'd4);
      run_phase(2);
      settle();

      c_thr = cdh_pkg::THR_W'($urandom_range(1, 12));
      write_thresholds(c_thr, cdh_pkg::THR_W'($urandom_range(0, c_thr)),
                       cdh_pkg::THR_W'($urandom_range(0, 10)));
      run_phase(3);
      settle();

      write_thresholds(11'd3, 11'd6, 11'd1);
      no_gaps = 1'b1;
      run_phase(NO_CAL);
      settle();
      no_gaps = 1'b0;

      write_thresholds(11'd2046, 11'd0, 11'd2046);
      run_phase(NO_CAL);
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
